// ===== hdl/bale_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bale_pkg: shared types and constants of the bounded array list engine
// Capacity, widths, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package bale_pkg;

  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Fixed field widths of the channels.
  localparam int CMD_W   = 3;
  localparam int POS_W   = 4;
  localparam int ITEM_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_LENGTH = 2'd2;

  typedef logic [WORD_WIDTH-1:0] word_t;

  // Broadcast to every cell of the row in each cycle.
  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [IDX_W-1:0] pos;
    word_t            item;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/bale_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bale_in_if: command channel of the list engine
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface bale_in_if
  import bale_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  position;
  logic [ITEM_W-1:0] item_word;

  modport source (output valid, cmd, position, item_word, input ready);
  modport sink   (input valid, cmd, position, item_word, output ready);
endinterface
`default_nettype wire

// ===== hdl/bale_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bale_out_if: result channel of the list engine
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface bale_out_if
  import bale_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ITEM_W-1:0]  read_word;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] entry_count;
  logic               full_flag;
  logic               empty_flag;

  modport source (output valid, read_word, status, entry_count, full_flag, empty_flag,
                  input ready);
  modport sink   (input valid, read_word, status, entry_count, full_flag, empty_flag,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/bale_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bale_cell: one list entry
// Holds one word and loads the new item, its left neighbor or its right
// neighbor, depending on the broadcast command and its own index.
// ----------------------------------------------------------------------------
module bale_cell
  import bale_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire cell_ctrl_t       ctrl,
  input  wire word_t            left_word,
  input  wire word_t            right_word,
  output word_t                 entry_word,
  output word_t                 sel_word
);

  word_t entry_r;
  word_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en) begin
      if (cell_idx == ctrl.pos) begin
        entry_nxt = ctrl.item;
      end else if (cell_idx > ctrl.pos) begin
        entry_nxt = left_word;
      end
    end else if (ctrl.rem_en) begin
      if (cell_idx >= ctrl.pos) begin
        entry_nxt = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_word = entry_r;
  // Only the addressed cell puts its word on the read bus.
  assign sel_word   = (cell_idx == ctrl.pos) ? entry_r : '0;

endmodule
`default_nettype wire

// ===== hdl/bounded_array_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_array_list_engine: fixed-capacity ordered list of words
// A row of entry cells with a count register and a registered result.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command word per handshake: cmd (push, pop, insert,
//   remove, get), position and item_word. out_ch returns exactly one result
//   word per command: read_word, status, entry_count, full_flag, empty_flag.
//   A command is executed in the cycle it is accepted; every cell of the row
//   loads its new value at that edge, taking the item or the word of a
//   neighbor, so inserts and removes shift the whole list at once. The result
//   appears on out_ch in the cycle after acceptance, and a new command can be
//   accepted every cycle while the receiver takes each result, so the throughput
//   is one command per cycle. The figure is set by the single output register:
//   in_ch.ready is high when that register is empty or is being emptied in the
//   same cycle. When the receiver stalls, the result is held and in_ch.ready
//   drops until it is taken.
//   Reset (rst_n low, synchronous) empties the list and drops out_ch.valid.
//   Entry contents are not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
module bounded_array_list_engine
  import bale_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  bale_in_if.sink     in_ch,
  bale_out_if.source  out_ch
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  word_t            rd_r;
  logic [STAT_W-1:0] st_r;

  logic             in_accept;
  logic [CNT_W-1:0] pos_c;
  logic [STAT_W-1:0] st_c;
  word_t            rd_c;
  word_t            rd_bus;
  logic             ins_c;
  logic             rem_c;
  logic [IDX_W-1:0] ins_pos_c;
  cell_ctrl_t       ctrl;

  word_t entry_w [CAPACITY];
  word_t sel_w   [CAPACITY];

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign pos_c       = CNT_W'(in_ch.position);

  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | sel_w[i];
    end
  end

  always_comb begin
    st_c      = ST_OK;
    rd_c      = '0;
    ins_c     = 1'b0;
    rem_c     = 1'b0;
    ins_pos_c = IDX_W'(in_ch.position);
    cnt_nxt   = cnt_r;
    unique case (in_ch.cmd)
      CMD_PUSH: begin
        if (cnt_r >= CAP_C) begin
          st_c = ST_LENGTH;
        end else begin
          ins_c     = 1'b1;
          ins_pos_c = cnt_r[IDX_W-1:0];
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      CMD_POP: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      CMD_INSERT: begin
        if (pos_c >= CAP_C) begin
          st_c = ST_RANGE;
        end else if (cnt_r >= CAP_C || pos_c > cnt_r) begin
          st_c = ST_LENGTH;
        end else begin
          ins_c   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos_c >= cnt_r) begin
          st_c = ST_RANGE;
        end else begin
          rem_c   = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      CMD_GET: begin
        if (pos_c >= cnt_r) begin
          st_c = ST_RANGE;
        end else begin
          rd_c = rd_bus;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctrl.ins_en = in_accept && ins_c;
  assign ctrl.rem_en = in_accept && rem_c;
  assign ctrl.pos    = ins_pos_c;
  assign ctrl.item   = WORD_WIDTH'(in_ch.item_word);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end
    bale_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(g)),
      .ctrl       (ctrl),
      .left_word  (left_w),
      .right_word (right_w),
      .entry_word (entry_w[g]),
      .sel_word   (sel_w[g])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_r <= rd_c;
      st_r <= st_c;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_word   = ITEM_W'(rd_r);
  assign out_ch.status      = st_r;
  assign out_ch.entry_count = COUNT_W'(cnt_r);
  assign out_ch.full_flag   = (cnt_r == CAP_C);
  assign out_ch.empty_flag  = (cnt_r == '0);

  // The count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C)
    else $error("entry count exceeds capacity");

  // A push on a list that is not full grows it by one.
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_ch.cmd == CMD_PUSH && cnt_r < CAP_C
    |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("push did not grow the list");

  // A get below the count reports success.
  a_get_ok: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_ch.cmd == CMD_GET && pos_c < cnt_r
    |=> out_ch.valid && out_ch.status == ST_OK)
    else $error("get below count did not report ok");

  // Insert and remove never act in the same cycle.
  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.ins_en && ctrl.rem_en))
    else $error("insert and remove shift at once");

  // The list count changes only when a command is taken.
  a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(cnt_r))
    else $error("count changed without a command");

endmodule
`default_nettype wire
